// ----- sv/sac_pkg.sv -----
// Shared types and constants for the set-associative LRU cache simulator.
// No dependencies; every other file refers to it by scoped names.
package sac_pkg;

    // access kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    // register reset values and limits
    localparam logic [3:0] SET_BITS_RESET   = 4'd4;
    localparam logic [4:0] BLOCK_BITS_RESET = 5'd4;
    localparam logic [3:0] WAYS_RESET       = 4'd1;
    localparam logic [4:0] BLOCK_BITS_LIMIT = 5'd16;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    // outcome of one set lookup
    typedef struct packed {
        logic hit;
        logic evict;
    } lru_result_t;

endpackage

// ----- sv/sac_store.sv -----
// Set storage: one row per set holding every way's tag and valid bit.
// Synchronous memory with registered read plus per-row written flags.
// Depends on sac_pkg.
module sac_store #(
    parameter int unsigned MAX_SET_BITS = 8,
    parameter int unsigned MAX_WAYS     = 8
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           rd_en,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] rd_addr,
    output logic [MAX_WAYS-1:0][sac_pkg::TAG_W-1:0]        rd_tags,
    output logic [MAX_WAYS-1:0]                            rd_valids,
    input  logic                                           wr_en,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] wr_addr,
    input  logic [MAX_WAYS-1:0][sac_pkg::TAG_W-1:0]        wr_tags,
    input  logic [MAX_WAYS-1:0]                            wr_valids
);
    localparam int unsigned ROW_COUNT = 1 << MAX_SET_BITS;
    localparam int unsigned ROW_W     = MAX_WAYS * (sac_pkg::TAG_W + 1);

    logic [ROW_W-1:0]     mem [ROW_COUNT];
    logic [ROW_W-1:0]     rd_row_reg;
    logic [ROW_COUNT-1:0] row_ok_reg;
    logic                 rd_ok_reg;

    // row memory: write on update, registered read on lookup
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_valids, wr_tags};
        end
        if (rd_en) begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // track rows that hold written data; an unwritten row reads as all invalid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_ok_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= row_ok_reg[rd_addr];
            end
        end
    end

    assign rd_tags   = rd_row_reg[MAX_WAYS*sac_pkg::TAG_W-1:0];
    assign rd_valids = rd_ok_reg ? rd_row_reg[ROW_W-1:MAX_WAYS*sac_pkg::TAG_W]
                                 : '0;

endmodule

// ----- sv/sac_lru.sv -----
// Tag compare and true-LRU reorder of one set row.
// Way 0 is most recently used. Depends on sac_pkg.
module sac_lru #(
    parameter int unsigned MAX_WAYS = 8
) (
    input  logic [3:0]                              ways,
    input  logic [sac_pkg::TAG_W-1:0]               tag,
    input  logic [MAX_WAYS-1:0][sac_pkg::TAG_W-1:0] old_tags,
    input  logic [MAX_WAYS-1:0]                     old_valids,
    output logic [MAX_WAYS-1:0][sac_pkg::TAG_W-1:0] new_tags,
    output logic [MAX_WAYS-1:0]                     new_valids,
    output sac_pkg::lru_result_t                    result
);
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] shift_in;

    // compare every active way
    always_comb begin
        for (int k = 0; k < MAX_WAYS; k++) begin
            match[k] = old_valids[k] && (old_tags[k] == tag) && (k < int'(ways));
        end
    end

    // a way takes its neighbor's entry while no hit lies in front of it
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int k = 0; k < MAX_WAYS; k++) begin
            shift_in[k] = (k < int'(ways)) && !seen;
            seen = seen | match[k];
        end
    end

    // build the reordered row; the accessed tag enters at the front
    always_comb begin
        new_tags      = old_tags;
        new_valids    = old_valids;
        new_tags[0]   = tag;
        new_valids[0] = 1'b1;
        for (int k = 1; k < MAX_WAYS; k++) begin
            if (shift_in[k]) begin
                new_tags[k]   = old_tags[k-1];
                new_valids[k] = old_valids[k-1];
            end
        end
    end

    // a miss drops the last active way if it held a valid tag
    always_comb begin
        result.hit   = |match;
        result.evict = 1'b0;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if ((k + 1) == int'(ways) && !(|match) && old_valids[k]) begin
                result.evict = 1'b1;
            end
        end
    end

endmodule

// ----- sv/set_assoc_lru_cache_sim.sv -----
// Set-associative cache simulator with true LRU replacement and hit/miss counters.
// The set row is read when the word is accepted; the look state then compares, writes
// the row back and registers the result, waiting while a finished result is not taken.
// A new access waits for the idle state, after the single row memory read-modify-write.
// Reset (aresetn low, synchronous): registers to 4/4/1, counters and all valid
// bits cleared at once through per-row flags; no clearing pass.
// Depends on sac_pkg, sac_store and sac_lru.
module set_assoc_lru_cache_sim #(
    parameter int unsigned MAX_SET_BITS = 8,
    parameter int unsigned MAX_WAYS     = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // access input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // hit_total[31:0], miss_total[63:32], evict_total[95:64]
    output logic [1:0]  m_tuser    // was_hit[0], evicted[1]
);
    localparam int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int unsigned W     = sac_pkg::COUNT_W;

    sac_pkg::state_t state_reg, state_next;

    logic [3:0] set_bits_reg;
    logic [4:0] block_bits_reg;
    logic [3:0] ways_reg;

    logic [SET_W-1:0]          set_reg;
    logic [sac_pkg::TAG_W-1:0] tag_reg;
    logic [1:0]                kind_reg;

    logic [W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [W-1:0] miss_cnt_reg, miss_cnt_next;
    logic [W-1:0] evict_cnt_reg, evict_cnt_next;

    logic       m_valid_reg;
    logic [1:0] m_flags_reg;

    logic                      accept;
    logic                      out_free;
    logic                      update;
    logic [3:0]                sbits;
    logic [4:0]                bbits;
    logic [5:0]                shift;
    logic [31:0]               set_full;
    logic [SET_W-1:0]          set_in;
    logic [sac_pkg::TAG_W-1:0] tag_in;

    logic [MAX_WAYS-1:0][sac_pkg::TAG_W-1:0] rd_tags, wr_tags;
    logic [MAX_WAYS-1:0]                     rd_valids, wr_valids;
    sac_pkg::lru_result_t                    lru_res;

    // configuration: always ready, unsupported associativity dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= sac_pkg::SET_BITS_RESET;
            block_bits_reg <= sac_pkg::BLOCK_BITS_RESET;
            ways_reg       <= sac_pkg::WAYS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                sac_pkg::CFG_SET_BITS: begin
                    set_bits_reg <= cfg_data[3:0];
                end
                sac_pkg::CFG_BLOCK_BITS: begin
                    block_bits_reg <= cfg_data;
                end
                sac_pkg::CFG_WAYS: begin
                    if ((cfg_data[3:0] inside {4'd1, 4'd2, 4'd4, 4'd8}) &&
                        int'(cfg_data[3:0]) <= MAX_WAYS) begin
                        ways_reg <= cfg_data[3:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // split the address by the clamped geometry
    always_comb begin
        sbits    = (int'(set_bits_reg) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits_reg;
        bbits    = (block_bits_reg > sac_pkg::BLOCK_BITS_LIMIT) ? sac_pkg::BLOCK_BITS_LIMIT
                                                                : block_bits_reg;
        shift    = {2'b00, sbits} + {1'b0, bbits};
        set_full = (s_tdata >> bbits) & ((32'd1 << sbits) - 32'd1);
        set_in   = set_full[SET_W-1:0];
        tag_in   = (shift >= 6'd32) ? '0 : (s_tdata >> shift);
    end

    // handshake and sequencing
    assign s_tready = (state_reg == sac_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign update   = (state_reg == sac_pkg::ST_LOOK) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sac_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = sac_pkg::ST_LOOK;
                end
            end
            sac_pkg::ST_LOOK: begin
                if (out_free) begin
                    state_next = sac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sac_pkg::ST_IDLE;
            end
        endcase
    end

    // hold the access fields for the compare cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg  <= set_in;
            tag_reg  <= tag_in;
            kind_reg <= s_tuser;
        end
    end

    sac_store #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (set_in),
        .rd_tags  (rd_tags),
        .rd_valids(rd_valids),
        .wr_en    (update),
        .wr_addr  (set_reg),
        .wr_tags  (wr_tags),
        .wr_valids(wr_valids)
    );

    sac_lru #(
        .MAX_WAYS(MAX_WAYS)
    ) u_lru (
        .ways      (ways_reg),
        .tag       (tag_reg),
        .old_tags  (rd_tags),
        .old_valids(rd_valids),
        .new_tags  (wr_tags),
        .new_valids(wr_valids),
        .result    (lru_res)
    );

    // saturating totals; a modify adds one more hit
    always_comb begin
        logic [W:0] hit_sum;
        hit_sum = {1'b0, hit_cnt_reg} + {{W{1'b0}}, lru_res.hit}
                + {{W{1'b0}}, (kind_reg == sac_pkg::KIND_MODIFY)};
        hit_cnt_next   = hit_sum[W] ? sac_pkg::COUNT_MAX : hit_sum[W-1:0];
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        if (!lru_res.hit && miss_cnt_reg != sac_pkg::COUNT_MAX) begin
            miss_cnt_next = miss_cnt_reg + {{(W-1){1'b0}}, 1'b1};
        end
        if (lru_res.evict && evict_cnt_reg != sac_pkg::COUNT_MAX) begin
            evict_cnt_next = evict_cnt_reg + {{(W-1){1'b0}}, 1'b1};
        end
    end

    // state, counters and the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sac_pkg::ST_IDLE;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (update) begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            m_flags_reg <= {lru_res.evict, lru_res.hit};
        end
    end

    // totals change only when a new word loads, so they drive the output directly
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_flags_reg;
    assign m_tdata  = {evict_cnt_reg, miss_cnt_reg, hit_cnt_reg};

    // an accepted word goes straight to the compare cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == sac_pkg::ST_LOOK)
        else $error("accepted word did not enter the compare cycle");

    // no write back while a pending result is still held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !update)
        else $error("row updated while the output word was stalled");

    // a result word cannot be both a hit and an eviction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_flags_reg[0] && m_flags_reg[1]))
        else $error("hit and eviction flagged together");

    // totals never decrease between resets
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (hit_cnt_reg >= $past(hit_cnt_reg)) &&
                           (miss_cnt_reg >= $past(miss_cnt_reg)) &&
                           (evict_cnt_reg >= $past(evict_cnt_reg)))
        else $error("running total decreased");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for the set-associative LRU cache simulator: directed and random
// accesses over several geometries, checked against an LRU predictor.
// Depends on sac_pkg and the set_assoc_lru_cache_sim RTL.
module testbench;

    localparam int unsigned SET_BITS_CAP = 8;
    localparam int unsigned WAY_CAP      = 8;
    localparam int unsigned SET_COUNT    = 1 << SET_BITS_CAP;
    // Limit on the run length, above the slowest correct run.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef struct {
        bit          was_hit;
        bit          evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } cache_outcome_t;

    // LRU cache predictor plus the store of outcomes still to arrive
    class lru_cache_model;
        logic [3:0]  set_bits;
        logic [4:0]  block_bits;
        logic [3:0]  ways;
        logic [31:0] tag_mem [SET_COUNT][WAY_CAP];
        bit          valid_mem [SET_COUNT][WAY_CAP];
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
        cache_outcome_t pending_outcomes[$];
        int errors;

        function new();
            set_bits   = sac_pkg::SET_BITS_RESET;
            block_bits = sac_pkg::BLOCK_BITS_RESET;
            ways       = sac_pkg::WAYS_RESET;
            hits       = '0;
            misses     = '0;
            evicts     = '0;
            errors     = 0;
            for (int s = 0; s < SET_COUNT; s++) begin
                for (int w = 0; w < WAY_CAP; w++) begin
                    tag_mem[s][w]   = '0;
                    valid_mem[s][w] = 1'b0;
                end
            end
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == sac_pkg::COUNT_MAX) ? v : v + 32'd1;
        endfunction

        function int unsigned eff_set_bits();
            return (set_bits > SET_BITS_CAP) ? SET_BITS_CAP : set_bits;
        endfunction

        function int unsigned eff_block_bits();
            return (block_bits > sac_pkg::BLOCK_BITS_LIMIT) ? sac_pkg::BLOCK_BITS_LIMIT
                                                            : block_bits;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function void write_register(logic [1:0] idx, logic [4:0] data);
            logic [3:0] w;
            w = data[3:0];
            case (idx)
                sac_pkg::CFG_SET_BITS: begin
                    set_bits = data[3:0];
                end
                sac_pkg::CFG_BLOCK_BITS: begin
                    block_bits = data;
                end
                sac_pkg::CFG_WAYS: begin
                    // keep the old value on an unsupported associativity
                    if ((w == 4'd1 || w == 4'd2 || w == 4'd4 || w == 4'd8) && w <= WAY_CAP)
                        ways = w;
                end
                default: begin
                end
            endcase
        endfunction

        // Look up one accepted access, update LRU order and totals
        function void record_access(logic [1:0] kind, logic [31:0] addr);
            int unsigned sb;
            int unsigned bb;
            int unsigned set_idx;
            int unsigned nw;
            int unsigned top;
            logic [31:0] tag;
            bit hit;
            bit ev;
            cache_outcome_t o;
            sb = eff_set_bits();
            bb = eff_block_bits();
            set_idx = (addr >> bb) & ((32'd1 << sb) - 32'd1);
            tag = addr >> (sb + bb);
            nw = ways;
            hit = 1'b0;
            top = 0;
            for (int i = 0; i < nw; i++) begin
                if (!hit && valid_mem[set_idx][i] && tag_mem[set_idx][i] == tag) begin
                    hit = 1'b1;
                    top = i;
                end
            end
            if (hit) begin
                ev = 1'b0;
            end else begin
                ev = valid_mem[set_idx][nw-1];
                top = nw - 1;
            end
            // shift ways in front of the slot back by one, new tag to the front
            for (int k = top; k > 0; k--) begin
                tag_mem[set_idx][k]   = tag_mem[set_idx][k-1];
                valid_mem[set_idx][k] = valid_mem[set_idx][k-1];
            end
            tag_mem[set_idx][0]   = tag;
            valid_mem[set_idx][0] = 1'b1;
            if (hit)
                hits = bump(hits);
            else
                misses = bump(misses);
            if (ev)
                evicts = bump(evicts);
            if (kind == sac_pkg::KIND_MODIFY)
                hits = bump(hits);
            o.was_hit     = hit;
            o.evicted     = ev;
            o.hit_total   = hits;
            o.miss_total  = misses;
            o.evict_total = evicts;
            pending_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Check one result word against the oldest outcome
        function void check_outcome(logic [1:0] user, logic [95:0] data);
            cache_outcome_t o;
            if (pending_outcomes.size() == 0) begin
                $error("result word with no access pending: tuser %0h tdata %0h", user, data);
                errors++;
                return;
            end
            o = pending_outcomes.pop_front();
            compare_field("was_hit", o.was_hit, user[0]);
            compare_field("evicted", o.evicted, user[1]);
            compare_field("hit_total", o.hit_total, data[31:0]);
            compare_field("miss_total", o.miss_total, data[63:32]);
            compare_field("evict_total", o.evict_total, data[95:64]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    lru_cache_model lru_cache = new();

    int unsigned cycles = 0;
    int unsigned send_idle_pct = 7;
    int unsigned recv_idle_pct = 73;
    bit          hold_request = 1'b0;

    set_assoc_lru_cache_sim #(
        .MAX_SET_BITS(SET_BITS_CAP),
        .MAX_WAYS    (WAY_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL set_assoc_lru_cache_sim");
            $finish;
        end
    end

    // Check every result word taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            lru_cache.check_outcome(m_tuser, m_tdata);
    end

    // Drive the result side: random idling, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one access word and hold it until taken
    task automatic send_access(logic [1:0] kind, logic [31:0] addr);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = addr;
        do @(posedge aclk); while (!s_tready);
        lru_cache.record_access(kind, addr);
    endtask

    // Write one register word
    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        lru_cache.write_register(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid, then wait for every pending result plus the pipeline depth
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (lru_cache.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [4:0]  ph_set   [10] = '{5'd2, 5'd3, 5'd0, 5'd8, 5'd31,
                                       5'd1, 5'd5, 5'd2, 5'd0, 5'd6};
        logic [4:0]  ph_block [10] = '{5'd4, 5'd5, 5'd0, 5'd16, 5'd31,
                                       5'd2, 5'd3, 5'd6, 5'd4, 5'd0};
        logic [4:0]  ph_ways  [10] = '{5'd2, 5'd4, 5'd8, 5'd8, 5'd8,
                                       5'd1, 5'd4, 5'd8, 5'd2, 5'd1};
        logic [4:0]  ph_bad   [10] = '{5'd3, 5'd0, 5'd5, 5'd31, 5'd9,
                                       5'd6, 5'd12, 5'd7, 5'd10, 5'd11};
        int unsigned ph_count [10] = '{150, 150, 100, 150, 100,
                                       100, 150, 150, 100, 100};
        logic [31:0] tag_pool [12];
        logic [31:0] set_pool [4];
        int unsigned n_tags;
        int unsigned sb;
        int unsigned bb;
        int unsigned sent;
        logic [31:0] addr;
        logic [31:0] offset;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        sent      = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset geometry: 16 sets, 16-byte blocks, direct mapped
        send_access(sac_pkg::KIND_LOAD, 32'h0000_0000);
        send_access(sac_pkg::KIND_LOAD, 32'h0000_0000);
        send_access(sac_pkg::KIND_STORE, 32'h0000_000F);
        send_access(sac_pkg::KIND_MODIFY, 32'h0000_0000);
        send_access(2'd3, 32'h0000_0010);
        send_access(sac_pkg::KIND_LOAD, 32'hFFFF_FFFF);
        send_access(sac_pkg::KIND_LOAD, 32'hFFFF_FF0F);
        send_access(sac_pkg::KIND_MODIFY, 32'h0000_0100);
        send_access(sac_pkg::KIND_STORE, 32'hFFFF_FFFF);
        wait_idle();

        // No set or block bits: the tag is the whole address
        write_reg(sac_pkg::CFG_SET_BITS, 5'd0);
        write_reg(sac_pkg::CFG_BLOCK_BITS, 5'd0);
        send_access(sac_pkg::KIND_LOAD, 32'h0000_0000);
        send_access(sac_pkg::KIND_LOAD, 32'hFFFF_FFFF);
        send_access(sac_pkg::KIND_MODIFY, 32'hFFFF_FFFF);
        send_access(sac_pkg::KIND_LOAD, 32'h1234_5678);
        wait_idle();

        // Widest geometry: overfill one set, then touch a middle way
        write_reg(sac_pkg::CFG_SET_BITS, 5'd8);
        write_reg(sac_pkg::CFG_BLOCK_BITS, 5'd16);
        write_reg(sac_pkg::CFG_WAYS, 5'd8);
        for (int j = 0; j < 9; j++)
            send_access(sac_pkg::KIND_LOAD, j << 24);
        send_access(sac_pkg::KIND_STORE, 32'h0000_0000);
        send_access(sac_pkg::KIND_LOAD, 32'h0400_FFFF);
        wait_idle();

        // Unsupported associativity and an unused index must leave state alone
        write_reg(sac_pkg::CFG_WAYS, 5'd3);
        write_reg(sac_pkg::CFG_WAYS, 5'd0);
        write_reg(2'd3, 5'd31);

        for (int p = 0; p < 10; p++) begin
            write_reg(sac_pkg::CFG_SET_BITS, ph_set[p]);
            write_reg(sac_pkg::CFG_BLOCK_BITS, ph_block[p]);
            write_reg(sac_pkg::CFG_WAYS, ph_ways[p]);
            write_reg(sac_pkg::CFG_WAYS, ph_bad[p]);
            sb = lru_cache.eff_set_bits();
            bb = lru_cache.eff_block_bits();
            // small pools of tags and sets so that accesses hit and evict
            n_tags = lru_cache.ways + 3;
            for (int t = 0; t < n_tags; t++)
                tag_pool[t] = $urandom;
            for (int s = 0; s < 4; s++)
                set_pool[s] = $urandom;

            for (int i = 0; i < ph_count[p]; i++) begin
                if (sent < 420) begin
                    send_idle_pct = 7;
                    recv_idle_pct = 73;
                end else if (sent < 840) begin
                    send_idle_pct = 73;
                    recv_idle_pct = 7;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (p == 3 && i == 40)
                    hold_request = 1'b1;
                if (p == 6 && i == 60)
                    wait_idle();
                offset = $urandom;
                if ($urandom_range(0, 99) < 85)
                    addr = (tag_pool[$urandom_range(0, n_tags - 1)] << (sb + bb))
                         | ((set_pool[$urandom_range(0, 3)] & ((32'd1 << sb) - 32'd1)) << bb)
                         | (offset & ((32'd1 << bb) - 32'd1));
                else
                    addr = $urandom;
                send_access(2'($urandom_range(0, 3)), addr);
                sent++;
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (lru_cache.errors == 0 && lru_cache.pending() == 0) begin
            $display("PASS set_assoc_lru_cache_sim");
        end else begin
            $display("FAIL set_assoc_lru_cache_sim");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/sac_pkg.sv
sv/sac_store.sv
sv/sac_lru.sv
sv/set_assoc_lru_cache_sim.sv
dv/testbench.sv
